/* src/dpft_pkg.sv */
// Shared types and constants for the demand-paging translator.
`timescale 1ns / 1ps
package dpft_pkg;

   localparam int ADDR_W      = 16;    // logical address beat width
   localparam int FRAME_NUM_W = 7;     // frame number port width
   localparam int PHYS_ADDR_W = 15;    // physical address port width
   localparam int EV_PAGE_W   = 8;     // evicted page port width
   localparam int CSR_W       = 8;     // frames_in_use register width
   localparam logic [CSR_W-1:0] CSR_FRAMES_RESET = 8'd128;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_EVICT,
      ST_COMMIT
   } dpft_state_type;

endpackage

/* src/demand_paging_fifo_translator.sv */
// Top level: demand-paging address translator with FIFO frame replacement.
`timescale 1ns / 1ps
// Usage:
//  - Command channel: a beat is taken on a clock edge with start high and
//    busy low; req_logical_address carries page (upper bits) and offset.
//  - Result channel: rsp_valid strobes for one cycle with the frame, the
//    physical address, the fault flag and eviction details. The receiver
//    cannot stall; every result must be captured in its strobe cycle.
//  - csr_wr_en/csr_wr_data write frames_in_use (clamped to 1..frames);
//    write only while busy is low.
//  - A hit's result is registered in the lookup state, a fault's in the
//    commit state after lookup and evict. A new beat may be taken in the
//    cycle the result strobes. The pace is set by the page-table RAM: one
//    registered read, then the old page's invalidate and the new page's
//    write share its write port; the frame-owner RAM holds the owners.
//  - After reset the page table is swept clear, one entry per cycle, over
//    all VIRTUAL_PAGES entries (256 by default); busy stays high meanwhile.
//    CSR writes are taken during the sweep.
module demand_paging_fifo_translator #(
   parameter int PAGE_BYTES      = 256,
   parameter int VIRTUAL_PAGES   = 256,
   parameter int PHYSICAL_FRAMES = 128
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [dpft_pkg::ADDR_W-1:0]      req_logical_address,
   output logic                             rsp_valid,
   output logic [dpft_pkg::FRAME_NUM_W-1:0] rsp_frame_number,
   output logic [dpft_pkg::PHYS_ADDR_W-1:0] rsp_physical_address,
   output logic                             rsp_page_fault,
   output logic                             rsp_evicted_valid,
   output logic [dpft_pkg::EV_PAGE_W-1:0]   rsp_evicted_page,
   input  logic                             csr_wr_en,
   input  logic [dpft_pkg::CSR_W-1:0]       csr_wr_data
);
   import dpft_pkg::*;

   localparam int OFFSET_W = $clog2(PAGE_BYTES);
   localparam int PAGE_W   = $clog2(VIRTUAL_PAGES);
   localparam int FRAME_W  = $clog2(PHYSICAL_FRAMES);
   localparam int PTE_W    = FRAME_W + 1;     // {resident, frame}

   dpft_state_type state_ff, state_in;

   // CSR
   logic [CSR_W-1:0] frames_ff;

   // request latch
   logic [PAGE_W-1:0]   page_ff, page_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [ADDR_W-1:0]   addr_shifted;

   // clearing sweep
   logic [PAGE_W-1:0] clr_ff, clr_in;

   // victim info latched at lookup
   logic [FRAME_W-1:0] victim;
   logic               occupied;
   logic [FRAME_W-1:0] victim_ff, victim_in;
   logic               occ_ff, occ_in;
   logic               advance;

   // eviction details
   logic               ev_valid_ff, ev_valid_in;
   logic [PAGE_W-1:0]  ev_page_ff, ev_page_in;

   // page table RAM
   logic              pt_we;
   logic [PAGE_W-1:0] pt_waddr, pt_raddr;
   logic [PTE_W-1:0]  pt_wdata, pt_rdata;

   // frame owner RAM
   logic               fo_we;
   logic [FRAME_W-1:0] fo_waddr, fo_raddr;
   logic [PAGE_W-1:0]  fo_wdata, fo_rdata;

   // result registers
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [FRAME_NUM_W-1:0] rsp_frame_ff, rsp_frame_in;
   logic [PHYS_ADDR_W-1:0] rsp_phys_ff, rsp_phys_in;
   logic                   rsp_fault_ff, rsp_fault_in;
   logic                   rsp_evv_ff, rsp_evv_in;
   logic [EV_PAGE_W-1:0]   rsp_evp_ff, rsp_evp_in;

   logic [FRAME_W-1:0] out_frame;
   logic [31:0]        frame_wide;
   logic [31:0]        phys_wide;
   logic [31:0]        evp_wide;

   dpft_ram #(
      .WIDTH (PTE_W),
      .DEPTH (VIRTUAL_PAGES)
   ) u_page_table (
      .clock   (clock),
      .wr_en   (pt_we),
      .wr_addr (pt_waddr),
      .wr_data (pt_wdata),
      .rd_addr (pt_raddr),
      .rd_data (pt_rdata)
   );

   dpft_ram #(
      .WIDTH (PAGE_W),
      .DEPTH (PHYSICAL_FRAMES)
   ) u_frame_owner (
      .clock   (clock),
      .wr_en   (fo_we),
      .wr_addr (fo_waddr),
      .wr_data (fo_wdata),
      .rd_addr (fo_raddr),
      .rd_data (fo_rdata)
   );

   dpft_victim #(
      .PHYSICAL_FRAMES (PHYSICAL_FRAMES)
   ) u_victim (
      .clock         (clock),
      .reset         (reset),
      .frames_in_use (frames_ff),
      .advance       (advance),
      .victim        (victim),
      .occupied      (occupied)
   );

   assign addr_shifted = req_logical_address >> OFFSET_W;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         frames_ff    <= CSR_FRAMES_RESET;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            frames_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      page_ff      <= page_in;
      offset_ff    <= offset_in;
      victim_ff    <= victim_in;
      occ_ff       <= occ_in;
      ev_valid_ff  <= ev_valid_in;
      ev_page_ff   <= ev_page_in;
      rsp_frame_ff <= rsp_frame_in;
      rsp_phys_ff  <= rsp_phys_in;
      rsp_fault_ff <= rsp_fault_in;
      rsp_evv_ff   <= rsp_evv_in;
      rsp_evp_ff   <= rsp_evp_in;
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      page_in      = page_ff;
      offset_in    = offset_ff;
      victim_in    = victim_ff;
      occ_in       = occ_ff;
      ev_valid_in  = ev_valid_ff;
      ev_page_in   = ev_page_ff;
      rsp_valid_in = 1'b0;
      rsp_frame_in = rsp_frame_ff;
      rsp_phys_in  = rsp_phys_ff;
      rsp_fault_in = rsp_fault_ff;
      rsp_evv_in   = rsp_evv_ff;
      rsp_evp_in   = rsp_evp_ff;
      advance      = 1'b0;

      pt_we    = 1'b0;
      pt_waddr = page_ff;
      pt_wdata = '0;
      pt_raddr = page_ff;
      fo_we    = 1'b0;
      fo_waddr = victim_ff;
      fo_wdata = page_ff;
      fo_raddr = victim;

      out_frame  = pt_rdata[FRAME_W-1:0];
      frame_wide = '0;
      phys_wide  = '0;
      evp_wide   = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            // sweep: every page non-resident
            pt_we    = 1'b1;
            pt_waddr = clr_ff;
            pt_wdata = '0;
            clr_in   = clr_ff + PAGE_W'(1);
            if (clr_ff == PAGE_W'(VIRTUAL_PAGES - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            page_in   = addr_shifted[PAGE_W-1:0];
            offset_in = req_logical_address[OFFSET_W-1:0];
            pt_raddr  = addr_shifted[PAGE_W-1:0];
            if (start) begin
               state_in = ST_LOOKUP;
            end
         end

         ST_LOOKUP: begin
            // page table entry is on pt_rdata
            if (pt_rdata[PTE_W-1]) begin
               out_frame    = pt_rdata[FRAME_W-1:0];
               frame_wide   = 32'(out_frame);
               phys_wide    = 32'({out_frame, offset_ff});
               rsp_valid_in = 1'b1;
               rsp_frame_in = frame_wide[FRAME_NUM_W-1:0];
               rsp_phys_in  = phys_wide[PHYS_ADDR_W-1:0];
               rsp_fault_in = 1'b0;
               rsp_evv_in   = 1'b0;
               rsp_evp_in   = '0;
               state_in     = ST_IDLE;
            end else begin
               // miss: owner of the victim frame read here
               fo_raddr  = victim;
               victim_in = victim;
               occ_in    = occupied;
               state_in  = ST_EVICT;
            end
         end

         ST_EVICT: begin
            // drop the displaced page and claim the frame
            if (occ_ff) begin
               pt_we    = 1'b1;
               pt_waddr = fo_rdata;
               pt_wdata = '0;
            end
            ev_valid_in = occ_ff;
            ev_page_in  = occ_ff ? fo_rdata : '0;
            fo_we       = 1'b1;
            fo_waddr    = victim_ff;
            fo_wdata    = page_ff;
            state_in    = ST_COMMIT;
         end

         ST_COMMIT: begin
            pt_we        = 1'b1;
            pt_waddr     = page_ff;
            pt_wdata     = {1'b1, victim_ff};
            advance      = 1'b1;
            frame_wide   = 32'(victim_ff);
            phys_wide    = 32'({victim_ff, offset_ff});
            evp_wide     = 32'(ev_page_ff);
            rsp_valid_in = 1'b1;
            rsp_frame_in = frame_wide[FRAME_NUM_W-1:0];
            rsp_phys_in  = phys_wide[PHYS_ADDR_W-1:0];
            rsp_fault_in = 1'b1;
            rsp_evv_in   = ev_valid_ff;
            rsp_evp_in   = evp_wide[EV_PAGE_W-1:0];
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy                 = (state_ff != ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_frame_number     = rsp_frame_ff;
   assign rsp_physical_address = rsp_phys_ff;
   assign rsp_page_fault       = rsp_fault_ff;
   assign rsp_evicted_valid    = rsp_evv_ff;
   assign rsp_evicted_page     = rsp_evp_ff;

endmodule

/* src/dpft_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module dpft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/dpft_victim.sv */
// Round-robin victim pointer, frame count clamp and occupied-frame fill mark.
`timescale 1ns / 1ps
module dpft_victim #(
   parameter int PHYSICAL_FRAMES = 128
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [dpft_pkg::CSR_W-1:0]         frames_in_use,
   input  logic                               advance,
   output logic [$clog2(PHYSICAL_FRAMES)-1:0] victim,
   output logic                               occupied
);
   import dpft_pkg::*;

   localparam int FRAME_W = $clog2(PHYSICAL_FRAMES);
   localparam int CNT_W   = FRAME_W + 1;

   logic [FRAME_W-1:0] next_victim_ff, next_victim_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;   // frames below this mark hold a page
   logic [CNT_W-1:0]   count;
   logic [15:0]        cfg_wide;
   logic [CNT_W-1:0]   victim_ext;
   logic [CNT_W-1:0]   victim_inc;

   // clamp the frame count to 1..PHYSICAL_FRAMES
   always_comb begin
      cfg_wide = 16'(frames_in_use);
      if (cfg_wide == 16'd0) begin
         count = CNT_W'(1);
      end else if (cfg_wide > 16'(PHYSICAL_FRAMES)) begin
         count = CNT_W'(PHYSICAL_FRAMES);
      end else begin
         count = CNT_W'(cfg_wide);
      end
   end

   always_comb begin
      // pointer left past a lowered count restarts at frame 0
      if ({1'b0, next_victim_ff} >= count) begin
         victim = '0;
      end else begin
         victim = next_victim_ff;
      end
      victim_ext = {1'b0, victim};
      victim_inc = victim_ext + CNT_W'(1);
      occupied   = victim_ext < fill_ff;

      next_victim_in = next_victim_ff;
      fill_in        = fill_ff;
      if (advance) begin
         next_victim_in = (victim_inc >= count) ? '0 : victim_inc[FRAME_W-1:0];
         if (victim_inc > fill_ff) begin
            fill_in = victim_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_victim_ff <= '0;
         fill_ff        <= '0;
      end else begin
         next_victim_ff <= next_victim_in;
         fill_ff        <= fill_in;
      end
   end

endmodule
